FILE: design/assert_macros.svh
// Assertion macros used by the timer table top level.
// Depends on nothing; users provide clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication checked at each rising clock edge outside reset.
`define ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked at each rising clock edge outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: design/swtt_pkg.sv
// Package for the timer slot table: sizes, codes and transaction types.
// Used by the controller, the datapath and the top level.
package swtt_pkg;
	localparam int NUM_SLOTS = 16;
	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int INDEX_SHIFT = 24;
	localparam logic [23:0] SALT_MASK = 24'hFFFFFF;
	localparam logic [31:0] NO_DEADLINE = 32'h7FFFFFFF;

	localparam logic [1:0] OP_SET = 2'd0;
	localparam logic [1:0] OP_RESET = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_RUN = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_BAD_DURATION = 3'd1;
	localparam logic [2:0] ST_TABLE_FULL = 3'd2;
	localparam logic [2:0] ST_NO_TIMER = 3'd3;
	localparam logic [2:0] ST_WRONG_TYPE = 3'd4;

	typedef struct packed {
		logic [1:0] operation;
		logic periodic;
		logic [31:0] timer_ident;
		logic signed [31:0] duration_ms;
		logic [31:0] elapsed_ms;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic fired;
		logic [31:0] result_ident;
		logic [3:0] result_slot;
		logic [31:0] next_timeout;
		logic last;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
		logic scan;
		logic finish;
		logic [IDX_W-1:0] idx;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full_run;
	} sts_t;
endpackage

FILE: design/swtt_ctrl.sv
// Controller state machine of the timer slot table.
// Depends on swtt_pkg; drives the datapath through ctl_t.
module swtt_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input swtt_pkg::sts_t sts,
	output swtt_pkg::ctl_t ctl
);
	import swtt_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	logic [1:0] state_q;
	logic [IDX_W-1:0] idx_q;

	// State and slot counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_EXEC;
				end
				S_EXEC: begin
					idx_q <= '0;
					state_q <= sts.full_run ? S_SCAN : S_IDLE;
				end
				S_SCAN: begin
					if (idx_q == IDX_W'(NUM_SLOTS - 1)) begin
						state_q <= S_FINISH;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_FINISH: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Commands decoded from the state.
	always_comb begin
		busy = (state_q != S_IDLE);
		ctl.load = (state_q == S_IDLE) && start;
		ctl.exec = (state_q == S_EXEC);
		ctl.scan = (state_q == S_SCAN);
		ctl.finish = (state_q == S_FINISH);
		ctl.idx = idx_q;
	end
endmodule

FILE: design/swtt_dp.sv
// Datapath of the timer slot table: slot store, timers and result register.
// Depends on swtt_pkg; commanded by swtt_ctrl.
module swtt_dp (
	input logic clk,
	input logic arst_n,
	input swtt_pkg::req_t request,
	input swtt_pkg::ctl_t ctl,
	output swtt_pkg::sts_t sts,
	output logic strobe,
	output swtt_pkg::rsp_t result
);
	import swtt_pkg::*;

	req_t req_q;
	logic [31:0] ident_q [NUM_SLOTS];
	logic [31:0] iv_q [NUM_SLOTS];
	logic [31:0] cd_q [NUM_SLOTS];
	logic [23:0] salt_q;
	logic [31:0] known_q;
	logic [31:0] cur_q;
	logic [31:0] best_q;
	logic strobe_q;
	rsp_t rsp_q;

	logic [31:0] dur;
	logic dur_ok;
	logic [7:0] lk_idx;
	logic in_range;
	logic any_free;
	logic [IDX_W-1:0] free_idx;
	logic [IDX_W-1:0] addr;
	logic [31:0] rd_ident, rd_iv, rd_cd;
	logic rd_live, rd_per;
	logic fast_run;
	logic [23:0] salt_n;

	logic wr_en;
	logic [31:0] wr_ident, wr_iv, wr_cd;
	logic emit;
	rsp_t rsp_n;
	logic [31:0] best_n, cur_n, known_n;
	logic [23:0] salt_d;
	logic [31:0] new_cd;

	// Request decode and first free slot search.
	always_comb begin
		dur = $unsigned(req_q.duration_ms);
		dur_ok = (dur != 32'd0) && !dur[31];
		lk_idx = req_q.timer_ident[31:INDEX_SHIFT];
		in_range = lk_idx < 8'(NUM_SLOTS);
		any_free = 1'b0;
		free_idx = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (iv_q[i] == 32'd0) begin
				any_free = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
		if (ctl.scan) addr = ctl.idx;
		else if (req_q.operation == OP_SET) addr = free_idx;
		else addr = lk_idx[IDX_W-1:0];
		rd_ident = ident_q[addr];
		rd_iv = iv_q[addr];
		rd_cd = cd_q[addr];
		rd_live = (rd_iv != 32'd0);
		rd_per = rd_live && !rd_iv[31];
		fast_run = (req_q.elapsed_ms < cur_q) && (known_q != 32'd0);
		sts.full_run = (req_q.operation == OP_RUN) && !fast_run;
		salt_n = (salt_q + 24'd1) & SALT_MASK;
	end

	// Operation logic: one slot write and at most one result per cycle.
	always_comb begin
		wr_en = 1'b0;
		wr_ident = rd_ident;
		wr_iv = rd_iv;
		wr_cd = rd_cd;
		emit = 1'b0;
		rsp_n = '0;
		rsp_n.last = 1'b1;
		best_n = best_q;
		cur_n = cur_q;
		known_n = known_q;
		salt_d = salt_q;
		new_cd = rd_cd;
		if (ctl.load) begin
			best_n = NO_DEADLINE;
		end
		if (ctl.exec) begin
			case (req_q.operation)
				OP_SET: begin
					emit = 1'b1;
					if (!dur_ok) begin
						rsp_n.status = ST_BAD_DURATION;
					end else if (!any_free) begin
						rsp_n.status = ST_TABLE_FULL;
					end else begin
						salt_d = salt_n;
						wr_en = 1'b1;
						wr_ident = {8'(free_idx), salt_n};
						wr_iv = req_q.periodic ? dur : (32'd0 - dur);
						wr_cd = dur;
						known_n = 32'd0;
						rsp_n.result_ident = wr_ident;
						rsp_n.result_slot = 4'(free_idx);
					end
				end
				OP_RESET, OP_CLEAR: begin
					emit = 1'b1;
					if (!in_range || rd_ident != req_q.timer_ident || !rd_live) begin
						rsp_n.status = ST_NO_TIMER;
					end else if (req_q.periodic != rd_per) begin
						rsp_n.status = ST_WRONG_TYPE;
					end else if (req_q.operation == OP_RESET && !dur_ok) begin
						rsp_n.status = ST_BAD_DURATION;
					end else begin
						wr_en = 1'b1;
						if (req_q.operation == OP_RESET) begin
							wr_iv = req_q.periodic ? dur : 32'hFFFFFFFF;
							wr_cd = dur;
						end else begin
							wr_ident = 32'd0;
							wr_iv = 32'd0;
							wr_cd = 32'd0;
						end
						known_n = 32'd0;
						rsp_n.result_ident = req_q.timer_ident;
						rsp_n.result_slot = 4'(addr);
					end
				end
				OP_RUN: begin
					if (fast_run) begin
						emit = 1'b1;
						cur_n = cur_q - req_q.elapsed_ms;
						rsp_n.next_timeout = cur_n;
					end
				end
				default: emit = 1'b0;
			endcase
		end
		// One slot of a full run: fire, reload or count down, then fold the minimum.
		if (ctl.scan && rd_live) begin
			wr_en = 1'b1;
			if (rd_cd <= known_q) begin
				emit = 1'b1;
				rsp_n.fired = 1'b1;
				rsp_n.last = 1'b0;
				rsp_n.result_ident = rd_ident;
				rsp_n.result_slot = 4'(ctl.idx);
				if (rd_per) begin
					new_cd = rd_iv;
				end else begin
					wr_ident = 32'd0;
					wr_iv = 32'd0;
					new_cd = 32'd0;
				end
			end else begin
				new_cd = rd_cd - known_q;
			end
			wr_cd = new_cd;
			if (wr_iv != 32'd0 && new_cd < best_q) best_n = new_cd;
		end
		if (ctl.finish) begin
			emit = 1'b1;
			known_n = best_q;
			cur_n = best_q;
			rsp_n.next_timeout = best_q;
		end
	end

	// Request latch and payload of the result register.
	always_ff @(posedge clk) begin
		if (ctl.load) req_q <= request;
		if (emit) rsp_q <= rsp_n;
	end

	// Slot store and timer state, cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				ident_q[i] <= 32'd0;
				iv_q[i] <= 32'd0;
				cd_q[i] <= 32'd0;
			end
			salt_q <= 24'd0;
			known_q <= 32'd0;
			cur_q <= 32'd0;
			best_q <= NO_DEADLINE;
			strobe_q <= 1'b0;
		end else begin
			if (wr_en) begin
				ident_q[addr] <= wr_ident;
				iv_q[addr] <= wr_iv;
				cd_q[addr] <= wr_cd;
			end
			salt_q <= salt_d;
			known_q <= known_n;
			cur_q <= cur_n;
			best_q <= best_n;
			strobe_q <= emit;
		end
	end

	assign strobe = strobe_q;
	assign result = rsp_q;
endmodule

FILE: design/multi_slot_software_timer_table_core.sv
// Timer slot table top level. Set, reset, clear and a short run pass the exec
// state and give a registered result strobe; a full run then scans each slot
// in turn, with fired results as slots expire, and ends with a final result.
// busy stays high until the final result strobe; results cannot be stalled.
// Asynchronous active-low reset empties every slot and clears all timers.
module multi_slot_software_timer_table_core (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input swtt_pkg::req_t request,
	output logic strobe,
	output swtt_pkg::rsp_t result
);
	import swtt_pkg::*;

	ctl_t ctl;
	sts_t sts;

	// Sequencer.
	swtt_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.sts(sts),
		.ctl(ctl)
	);

	// Slot store and result path.
	swtt_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.request(request),
		.ctl(ctl),
		.sts(sts),
		.strobe(strobe),
		.result(result)
	);

	// The end of a transaction always coincides with its final result.
	`include "assert_macros.svh"
	`ASSERT_NOW(a_fall_final, $fell(busy), strobe && result.last, "busy fell without final result")
	`ASSERT_NOW(a_last_idle, strobe && result.last, !busy, "final result while still busy")
	`ASSERT_NOW(a_mid_fired, strobe && !result.last, result.fired, "non-final result not fired")
	`ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted transaction did not raise busy")
endmodule

FILE: dv/swtt_checker.sv
// Checker for the timer slot table: watches the request and result channels,
// predicts each result from its own copy of the slot table and compares.
// Depends on swtt_pkg.
`timescale 1ns / 100ps
module swtt_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input swtt_pkg::req_t request,
	input logic strobe,
	input swtt_pkg::rsp_t result,
	output int errors,
	output int pending
);
	import swtt_pkg::*;

	logic [31:0] tbl_ident [NUM_SLOTS];
	logic [31:0] tbl_interval [NUM_SLOTS];
	logic [31:0] tbl_countdown [NUM_SLOTS];
	logic [23:0] salt;
	logic [31:0] deadline;
	logic [31:0] timeout;
	rsp_t expected_results [$];

	assign pending = expected_results.size();

	function automatic rsp_t make_rsp(logic [2:0] st, logic f, logic [31:0] id,
			logic [3:0] sl, logic [31:0] tmo, logic lst);
		rsp_t r;
		r.status = st;
		r.fired = f;
		r.result_ident = id;
		r.result_slot = sl;
		r.next_timeout = tmo;
		r.last = lst;
		return r;
	endfunction

	function automatic logic interval_periodic(logic [31:0] iv);
		return iv != 0 && !iv[31];
	endfunction

	// Advance the table by one accepted transaction and queue its results.
	task automatic predict_timer_op(req_t rq);
		logic [31:0] dur;
		logic dur_ok;
		logic [31:0] idx;
		logic [2:0] st;
		logic [31:0] prev;
		logic [31:0] best;
		int i;
		int free_slot;
		dur = rq.duration_ms;
		dur_ok = dur != 0 && !dur[31];
		case (rq.operation)
			OP_SET: begin
				free_slot = -1;
				for (i = NUM_SLOTS - 1; i >= 0; i--)
					if (tbl_interval[i] == 0) free_slot = i;
				if (!dur_ok)
					expected_results.push_back(make_rsp(ST_BAD_DURATION, 0, 0, 0, 0, 1));
				else if (free_slot < 0)
					expected_results.push_back(make_rsp(ST_TABLE_FULL, 0, 0, 0, 0, 1));
				else begin
					salt = salt + 24'd1;
					tbl_ident[free_slot] = {8'(free_slot), salt};
					tbl_interval[free_slot] = rq.periodic ? dur : -dur;
					tbl_countdown[free_slot] = dur;
					deadline = 0;
					expected_results.push_back(make_rsp(ST_OK, 0, tbl_ident[free_slot],
						4'(free_slot), 0, 1));
				end
			end
			OP_RESET, OP_CLEAR: begin
				idx = rq.timer_ident >> INDEX_SHIFT;
				st = ST_OK;
				if (idx >= NUM_SLOTS)
					st = ST_NO_TIMER;
				else if (tbl_ident[idx] != rq.timer_ident || tbl_interval[idx] == 0)
					st = ST_NO_TIMER;
				else if (rq.periodic != interval_periodic(tbl_interval[idx]))
					st = ST_WRONG_TYPE;
				else if (rq.operation == OP_RESET && !dur_ok)
					st = ST_BAD_DURATION;
				if (st != ST_OK)
					expected_results.push_back(make_rsp(st, 0, 0, 0, 0, 1));
				else begin
					if (rq.operation == OP_RESET) begin
						tbl_interval[idx] = rq.periodic ? dur : 32'hFFFFFFFF;
						tbl_countdown[idx] = dur;
					end else begin
						tbl_ident[idx] = 0;
						tbl_interval[idx] = 0;
						tbl_countdown[idx] = 0;
					end
					deadline = 0;
					expected_results.push_back(make_rsp(ST_OK, 0, rq.timer_ident,
						idx[3:0], 0, 1));
				end
			end
			default: begin
				if (rq.elapsed_ms < timeout && deadline != 0) begin
					timeout = timeout - rq.elapsed_ms;
					expected_results.push_back(make_rsp(ST_OK, 0, 0, 0, timeout, 1));
				end else begin
					prev = deadline;
					best = NO_DEADLINE;
					for (i = 0; i < NUM_SLOTS; i++) begin
						if (tbl_interval[i] == 0) continue;
						if (tbl_countdown[i] <= prev) begin
							expected_results.push_back(make_rsp(ST_OK, 1, tbl_ident[i],
								4'(i), 0, 0));
							if (interval_periodic(tbl_interval[i]))
								tbl_countdown[i] = tbl_interval[i];
							else begin
								tbl_ident[i] = 0;
								tbl_interval[i] = 0;
								tbl_countdown[i] = 0;
							end
						end else
							tbl_countdown[i] = tbl_countdown[i] - prev;
					end
					for (i = 0; i < NUM_SLOTS; i++)
						if (tbl_interval[i] != 0 && tbl_countdown[i] < best)
							best = tbl_countdown[i];
					deadline = best;
					timeout = best;
					expected_results.push_back(make_rsp(ST_OK, 0, 0, 0, best, 1));
				end
			end
		endcase
	endtask

	task automatic compare_result(rsp_t got);
		rsp_t exp_r;
		if (expected_results.size() == 0) begin
			$error("result with nothing expected: %p", got);
			errors++;
			return;
		end
		exp_r = expected_results.pop_front();
		if (got.status !== exp_r.status) begin
			$error("status: expected %0d, got %0d", exp_r.status, got.status);
			errors++;
		end
		if (got.fired !== exp_r.fired) begin
			$error("fired: expected %0d, got %0d", exp_r.fired, got.fired);
			errors++;
		end
		if (got.result_ident !== exp_r.result_ident) begin
			$error("result_ident: expected %h, got %h", exp_r.result_ident, got.result_ident);
			errors++;
		end
		if (got.result_slot !== exp_r.result_slot) begin
			$error("result_slot: expected %0d, got %0d", exp_r.result_slot, got.result_slot);
			errors++;
		end
		if (got.next_timeout !== exp_r.next_timeout) begin
			$error("next_timeout: expected %h, got %h", exp_r.next_timeout, got.next_timeout);
			errors++;
		end
		if (got.last !== exp_r.last) begin
			$error("last: expected %0d, got %0d", exp_r.last, got.last);
			errors++;
		end
	endtask

	// Results are compared before the accepted request is predicted, since a
	// result can never belong to a transaction accepted at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				tbl_ident[i] = 0;
				tbl_interval[i] = 0;
				tbl_countdown[i] = 0;
			end
			salt = 0;
			deadline = 0;
			timeout = 0;
			errors = 0;
			expected_results.delete();
		end else begin
			if (strobe === 1'b1)
				compare_result(result);
			if (start === 1'b1 && busy === 1'b0)
				predict_timer_op(request);
		end
	end
endmodule

FILE: dv/tb.sv
// Testbench top for the timer slot table: drives set, reset, clear and run
// transactions with random gaps and gives the verdict. Depends on swtt_pkg,
// multi_slot_software_timer_table_core and swtt_checker.
`timescale 1ns / 100ps
module tb;
	import swtt_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t request = '0;
	logic strobe;
	rsp_t result;
	int errors;
	int pending;
	int cycles = 0;
	int idle_pct = 16;
	logic [31:0] known_idents [$];

	always #5 clk = ~clk;

	multi_slot_software_timer_table_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.strobe(strobe),
		.result(result)
	);

	swtt_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.strobe(strobe),
		.result(result),
		.errors(errors),
		.pending(pending)
	);

	// Collect the identifiers handed out by set so that reset and clear hit.
	always @(posedge clk)
		if (strobe && result.status == ST_OK && !result.fired && result.result_ident != 0)
			known_idents.push_back(result.result_ident);

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Present one transaction and hold it until the block takes it.
	task automatic send_op(logic [1:0] op, logic per, logic [31:0] id,
			logic [31:0] dur, logic [31:0] el);
		while ($urandom_range(99) < idle_pct) @(negedge clk);
		request.operation = op;
		request.periodic = per;
		request.timer_ident = id;
		request.duration_ms = dur;
		request.elapsed_ms = el;
		start = 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
		start = 1'b0;
	endtask

	function automatic logic [31:0] pick_duration();
		case ($urandom_range(9))
			0: return $urandom();
			1: return 0;
			2: return 32'h7FFFFFFF;
			default: return $urandom_range(1, 200);
		endcase
	endfunction

	function automatic logic [31:0] pick_ident();
		int n;
		logic [31:0] id;
		n = known_idents.size();
		if (n > 0 && $urandom_range(3) != 0) begin
			id = known_idents[$urandom_range(n - 1)];
			if ($urandom_range(7) == 0) id[$urandom_range(31)] ^= 1'b1;
			return id;
		end
		return $urandom();
	endfunction

	initial begin
		int n;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: run on empty table, bad durations, extremes, fill the table.
		send_op(OP_RUN, 0, 0, 0, 0);
		send_op(OP_RUN, 0, 0, 0, 32'hFFFFFFFF);
		send_op(OP_SET, 1, 0, 0, 0);
		send_op(OP_SET, 0, 0, 32'h80000000, 0);
		send_op(OP_SET, 0, 0, 32'hFFFFFFFF, 0);
		send_op(OP_SET, 1, 0, 32'h7FFFFFFF, 0);
		send_op(OP_SET, 0, 0, 1, 0);
		for (int i = 0; i < 14; i++) send_op(OP_SET, i[0], 0, 5 + i, 0);
		send_op(OP_SET, 1, 0, 3, 0);
		send_op(OP_RESET, 1, 32'h0000_0001, 0, 0);
		send_op(OP_RESET, 0, 32'h0000_0001, 4, 0);
		send_op(OP_RESET, 1, 32'h0000_0001, 4, 0);
		send_op(OP_CLEAR, 0, 32'h0100_0002, 0, 0);
		send_op(OP_CLEAR, 0, 32'hFF00_0002, 0, 0);
		send_op(OP_RESET, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 0);
		send_op(OP_RUN, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 0);
		send_op(OP_RUN, 1, 0, 0, 2);
		send_op(OP_RUN, 0, 0, 0, 32'hFFFFFFFF);

		// Random: mostly sets, resets and clears (the latter two largely on collected identifiers) plus runs.
		for (int k = 0; k < 420; k++) begin
			idle_pct = (k >= 150 && k < 230) ? 0 : 16;
			n = $urandom_range(99);
			if (n < 30)
				send_op(OP_SET, 1'($urandom_range(1)), $urandom(), pick_duration(),
					$urandom());
			else if (n < 45)
				send_op(OP_RESET, 1'($urandom_range(1)), pick_ident(), pick_duration(),
					$urandom());
			else if (n < 57)
				send_op(OP_CLEAR, 1'($urandom_range(1)), pick_ident(), $urandom(),
					$urandom());
			else
				send_op(OP_RUN, 1'($urandom_range(1)), $urandom(), $urandom(),
					($urandom_range(9) == 0) ? $urandom() : $urandom_range(0, 120));
		end

		while (pending != 0) @(negedge clk);
		repeat (25) @(negedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

FILE: filelist.f
+incdir+design
design/swtt_pkg.sv
design/swtt_ctrl.sv
design/swtt_dp.sv
design/multi_slot_software_timer_table_core.sv
dv/swtt_checker.sv
dv/tb.sv
